// ----- hdl/mt_pkg.sv -----
// ----------------------------------------------------------------------------
// MT19937 shared definitions
// Constants, controller states, datapath operations and the command and
// status records that join the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mt_pkg;

  localparam int STATE_WORDS = 624;
  localparam int SHIFT_DIST = 397;

  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] TEMPER_B = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C = 32'hefc6_0000;
  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam logic [31:0] KEY_MULT_A = 32'd1664525;
  localparam logic [31:0] KEY_MULT_B = 32'd1566083941;
  localparam logic [31:0] ARRAY_BASE_SEED = 32'd19650218;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] HIGH_BIT = 32'h8000_0000;

  localparam logic [9:0] IDX_END = 10'd624;
  localparam logic [9:0] IDX_NEVER = 10'd625;
  localparam logic [9:0] IDX_LAST = 10'd623;

  typedef enum logic [1:0] {
    OPC_NEXT = 2'd0,
    OPC_RESEED = 2'd1,
    OPC_KEY = 2'd2,
    OPC_NONE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_WORD,
    MODE_RESEED,
    MODE_KEY
  } mode_t;

  typedef enum logic [1:0] {
    SEED_DEFAULT,
    SEED_CONFIG,
    SEED_BASE
  } seed_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SS_INIT,
    ST_SS_MUL,
    ST_SS_WR,
    ST_TW_INIT,
    ST_TW_A,
    ST_TW_B,
    ST_TW_C,
    ST_TW_D,
    ST_K_INIT,
    ST_K1_MUL,
    ST_K1_WR,
    ST_K1_WRAP,
    ST_K2_INIT,
    ST_K2_MUL,
    ST_K2_WR,
    ST_K2_WRAP,
    ST_K_END,
    ST_RD_A,
    ST_RD_B
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_KEY_PUT,
    OP_SS_INIT,
    OP_SS_MUL,
    OP_SS_WR,
    OP_TW_INIT,
    OP_TW_A,
    OP_TW_B,
    OP_TW_C,
    OP_TW_D,
    OP_K_INIT,
    OP_K1_MUL,
    OP_K1_WR,
    OP_K_WRAP,
    OP_K2_INIT,
    OP_K2_MUL,
    OP_K2_WR,
    OP_K_END,
    OP_RD_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    seed_sel_t seed_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic idx_never;
    logic idx_end;
    logic at_last;
    logic k_one;
    logic k_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/mt_datapath.sv -----
// ----------------------------------------------------------------------------
// MT19937 datapath
// State memory, key memory, the shared multiplier, loop counters, the
// seed register and the tempered output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mt_datapath import mt_pkg::*; #(
  parameter int KEY_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  output dp_status_t  status,
  input  logic [31:0] key_word,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata
);

  localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int CW = $clog2(KEY_MAX + 1);

  logic [31:0] mt_mem [STATE_WORDS];
  logic [31:0] key_mem [KEY_MAX];

  logic [31:0] seed_value;
  logic [9:0]  idx;
  logic [9:0]  n;
  logic [9:0]  k;
  logic [KW-1:0] j;
  logic [CW-1:0] kcount;
  logic [31:0] p;
  logic [31:0] prod;
  logic        hi;
  logic [30:0] lo;
  logic [31:0] rdata;
  logic [31:0] krdata;

  logic [9:0]  raddr;
  logic        we;
  logic [9:0]  waddr;
  logic [31:0] wdata;
  logic [31:0] mix;
  logic [31:0] mconst;
  logic [31:0] mul_lo;
  logic [9:0]  nx;
  logic [10:0] far_sum;
  logic [9:0]  far;
  logic [31:0] y;
  logic [31:0] tw_val;
  logic [31:0] ss_val;
  logic [31:0] k1_val;
  logic [31:0] k2_val;
  logic [31:0] seed_pick;
  logic [CW-1:0] j_inc;
  logic        load;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  assign mix = p ^ (p >> 30);
  assign mul_lo = mix * mconst;
  assign nx = (n == IDX_LAST) ? 10'd0 : n + 10'd1;
  assign far_sum = {1'b0, n} + 11'(SHIFT_DIST);
  assign far = (far_sum >= 11'(STATE_WORDS)) ? 10'(far_sum - 11'(STATE_WORDS))
                                             : far_sum[9:0];
  assign y = {hi, lo};
  assign tw_val = rdata ^ (y >> 1) ^ (y[0] ? TWIST_XOR : 32'd0);
  assign ss_val = prod + {22'd0, n};
  assign k1_val = (rdata ^ prod) + krdata + {{(32 - KW){1'b0}}, j};
  assign k2_val = (rdata ^ prod) - {22'd0, n};
  assign j_inc = CW'(j) + CW'(1);
  assign load = (cmd.op == OP_RD_LOAD);

  always_comb begin
    unique case (cmd.seed_sel)
      SEED_CONFIG: seed_pick = seed_value;
      SEED_BASE:   seed_pick = ARRAY_BASE_SEED;
      default:     seed_pick = DEFAULT_SEED;
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      OP_K1_MUL: mconst = KEY_MULT_A;
      OP_K2_MUL: mconst = KEY_MULT_B;
      default:   mconst = SEED_MULT;
    endcase
  end

  always_comb begin
    raddr = idx;
    we = 1'b0;
    waddr = n;
    wdata = p;
    unique case (cmd.op)
      OP_TW_A:   raddr = n;
      OP_TW_B:   raddr = nx;
      OP_TW_C:   raddr = far;
      OP_K1_MUL: raddr = n;
      OP_K2_MUL: raddr = n;
      OP_SS_INIT: begin
        we = 1'b1;
        waddr = 10'd0;
        wdata = seed_pick;
      end
      OP_SS_WR: begin
        we = 1'b1;
        wdata = ss_val;
      end
      OP_TW_D: begin
        we = 1'b1;
        wdata = tw_val;
      end
      OP_K1_WR: begin
        we = 1'b1;
        wdata = k1_val;
      end
      OP_K2_WR: begin
        we = 1'b1;
        wdata = k2_val;
      end
      OP_K_WRAP: begin
        we = 1'b1;
        waddr = 10'd0;
        wdata = p;
      end
      OP_K_END: begin
        we = 1'b1;
        waddr = 10'd0;
        wdata = HIGH_BIT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mt_mem[waddr] <= wdata;
    end
    rdata <= mt_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_KEY_PUT && kcount < CW'(KEY_MAX)) begin
      key_mem[kcount[KW-1:0]] <= key_word;
    end
    krdata <= key_mem[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= DEFAULT_SEED;
    end else if (cfg_we) begin
      seed_value <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= IDX_NEVER;
      kcount <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (cmd.op)
        OP_KEY_PUT: begin
          if (kcount < CW'(KEY_MAX)) begin
            kcount <= kcount + CW'(1);
          end
        end
        OP_SS_WR: begin
          if (n == IDX_LAST) begin
            idx <= IDX_END;
          end
        end
        OP_TW_D: begin
          if (n == IDX_LAST) begin
            idx <= 10'd0;
          end
        end
        OP_K_END: begin
          idx <= IDX_END;
          kcount <= '0;
        end
        OP_RD_LOAD: idx <= idx + 10'd1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= temper(rdata);
    end
    unique case (cmd.op)
      OP_SS_INIT: begin
        p <= seed_pick;
        n <= 10'd1;
      end
      OP_SS_MUL, OP_K1_MUL, OP_K2_MUL: prod <= mul_lo;
      OP_SS_WR: begin
        p <= ss_val;
        n <= n + 10'd1;
      end
      OP_TW_INIT: n <= 10'd0;
      OP_TW_B: hi <= rdata[31];
      OP_TW_C: lo <= rdata[30:0];
      OP_TW_D: n <= n + 10'd1;
      OP_K_INIT: begin
        p <= ARRAY_BASE_SEED;
        n <= 10'd1;
        j <= '0;
        k <= 10'(STATE_WORDS);
      end
      OP_K1_WR: begin
        p <= k1_val;
        n <= n + 10'd1;
        k <= k - 10'd1;
        j <= (j_inc >= kcount) ? '0 : j_inc[KW-1:0];
      end
      OP_K_WRAP: n <= 10'd1;
      OP_K2_INIT: k <= IDX_LAST;
      OP_K2_WR: begin
        p <= k2_val;
        n <= n + 10'd1;
        k <= k - 10'd1;
      end
      default: begin
      end
    endcase
  end

  assign status.idx_never = (idx == IDX_NEVER);
  assign status.idx_end = (idx >= IDX_END);
  assign status.at_last = (n == IDX_LAST);
  assign status.k_one = (k == 10'd1);
  assign status.k_zero = (k == 10'd0);
  assign status.out_free = !m_tvalid || m_tready;

endmodule

// ----- hdl/mt_controller.sv -----
// ----------------------------------------------------------------------------
// MT19937 controller
// Sequences seeding, twisting, key initialisation and word reads, one
// datapath operation per cycle except while idle or waiting on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mt_controller import mt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [1:0] s_tuser,
  input  logic       s_tlast,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  state_t state;
  state_t state_next;
  mode_t mode;
  mode_t mode_next;
  logic fire;
  opcode_t opc;

  assign s_tready = (state == ST_IDLE);
  assign fire = s_tvalid && s_tready;
  assign opc = opcode_t'(s_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mode <= MODE_WORD;
    end else begin
      state <= state_next;
      mode <= mode_next;
    end
  end

  always_comb begin
    state_next = state;
    mode_next = mode;
    unique case (state)
      ST_IDLE: begin
        if (fire) begin
          unique case (opc)
            OPC_NEXT: begin
              mode_next = MODE_WORD;
              if (status.idx_never) begin
                state_next = ST_SS_INIT;
              end else if (status.idx_end) begin
                state_next = ST_TW_INIT;
              end else begin
                state_next = ST_RD_A;
              end
            end
            OPC_RESEED: begin
              mode_next = MODE_RESEED;
              state_next = ST_SS_INIT;
            end
            OPC_KEY: begin
              if (s_tlast) begin
                mode_next = MODE_KEY;
                state_next = ST_SS_INIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SS_INIT: state_next = ST_SS_MUL;
      ST_SS_MUL:  state_next = ST_SS_WR;
      ST_SS_WR: begin
        if (!status.at_last) begin
          state_next = ST_SS_MUL;
        end else begin
          unique case (mode)
            MODE_WORD: state_next = ST_TW_INIT;
            MODE_KEY:  state_next = ST_K_INIT;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_TW_INIT: state_next = ST_TW_A;
      ST_TW_A:    state_next = ST_TW_B;
      ST_TW_B:    state_next = ST_TW_C;
      ST_TW_C:    state_next = ST_TW_D;
      ST_TW_D:    state_next = status.at_last ? ST_RD_A : ST_TW_A;
      ST_K_INIT:  state_next = ST_K1_MUL;
      ST_K1_MUL:  state_next = ST_K1_WR;
      ST_K1_WR: begin
        priority if (status.at_last) begin
          state_next = ST_K1_WRAP;
        end else if (status.k_one) begin
          state_next = ST_K2_INIT;
        end else begin
          state_next = ST_K1_MUL;
        end
      end
      ST_K1_WRAP: state_next = status.k_zero ? ST_K2_INIT : ST_K1_MUL;
      ST_K2_INIT: state_next = ST_K2_MUL;
      ST_K2_MUL:  state_next = ST_K2_WR;
      ST_K2_WR: begin
        priority if (status.at_last) begin
          state_next = ST_K2_WRAP;
        end else if (status.k_one) begin
          state_next = ST_K_END;
        end else begin
          state_next = ST_K2_MUL;
        end
      end
      ST_K2_WRAP: state_next = status.k_zero ? ST_K_END : ST_K2_MUL;
      ST_K_END:   state_next = ST_IDLE;
      ST_RD_A:    state_next = ST_RD_B;
      ST_RD_B:    state_next = status.out_free ? ST_IDLE : ST_RD_B;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    unique case (mode)
      MODE_RESEED: cmd.seed_sel = SEED_CONFIG;
      MODE_KEY:    cmd.seed_sel = SEED_BASE;
      default:     cmd.seed_sel = SEED_DEFAULT;
    endcase
    unique case (state)
      ST_IDLE: begin
        if (fire && opc == OPC_KEY) begin
          cmd.op = OP_KEY_PUT;
        end
      end
      ST_SS_INIT: cmd.op = OP_SS_INIT;
      ST_SS_MUL:  cmd.op = OP_SS_MUL;
      ST_SS_WR:   cmd.op = OP_SS_WR;
      ST_TW_INIT: cmd.op = OP_TW_INIT;
      ST_TW_A:    cmd.op = OP_TW_A;
      ST_TW_B:    cmd.op = OP_TW_B;
      ST_TW_C:    cmd.op = OP_TW_C;
      ST_TW_D:    cmd.op = OP_TW_D;
      ST_K_INIT:  cmd.op = OP_K_INIT;
      ST_K1_MUL:  cmd.op = OP_K1_MUL;
      ST_K1_WR:   cmd.op = OP_K1_WR;
      ST_K1_WRAP: cmd.op = OP_K_WRAP;
      ST_K2_INIT: cmd.op = OP_K2_INIT;
      ST_K2_MUL:  cmd.op = OP_K2_MUL;
      ST_K2_WR:   cmd.op = OP_K2_WR;
      ST_K2_WRAP: cmd.op = OP_K_WRAP;
      ST_K_END:   cmd.op = OP_K_END;
      ST_RD_B: begin
        if (status.out_free) begin
          cmd.op = OP_RD_LOAD;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/mt19937_word_generator.sv -----
// ----------------------------------------------------------------------------
// MT19937 word generator
// Standard 32-bit Mersenne Twister with single-seed and key initialisation.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group: s_tuser carries the opcode (next word,
// reseed, key word), s_tdata the key word and s_tlast marks the final key
// word. Tempered words leave on the m_ group. cfg_we writes cfg_wdata into
// the seed register used by a reseed request.
// One request is handled at a time; s_tready is high only while idle.
// A next word from a twisted state is read from the state memory in RD_A and
// tempered into m_tdata in RD_B; a further request is taken only in idle.
// Twisting the 624-word state takes three reads of the state memory and a
// write per word (the memory has a single read port), once every 624 words.
// A single-seed initialisation takes a multiply step and a write per word.
// A key initialisation is a single-seed initialisation and two key passes.
// A next word on a never seeded generator seeds with 5489 and twists first.
// Reset leaves the generator unseeded and clears the key count; the state
// memory needs no clearing pass. When the receiver stalls, the word waits
// in the output register; a further next-word request is accepted and then
// holds s_tready low until the waiting word has been taken.
`timescale 1ns / 1ps

module mt19937_word_generator import mt_pkg::*; #(
  parameter int KEY_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key_word
  input  logic [1:0]  s_tuser,   // opcode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // random_word
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  ctl_cmd_t cmd;
  dp_status_t status;

  mt_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .status   (status),
    .cmd      (cmd)
  );

  mt_datapath #(
    .KEY_MAX (KEY_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .key_word  (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
